/* design/mcpg_pkg.sv */
// Shared types, constants and helpers for the midpoint circle point generator.
// No dependencies; every other file in design/ refers to this package.
package mcpg_pkg;

    localparam int MAX_DIM_DEFAULT = 1024;
    localparam int DIM_W           = 11;
    localparam int COORD_W         = 8;
    localparam int RADIUS_W        = 8;
    localparam int COLOR_W         = 16;
    localparam int STEP_X_W        = 9;
    localparam int STEP_Y_W        = 10;
    localparam int DECISION_W      = 16;
    localparam int POINT_W         = 10;
    localparam int ADDR_W          = 21;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam logic [DIM_W-1:0] DIM_RESET = 11'd128;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef enum logic {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } reg_index_t;

    // One iteration's worth of work handed from front to back.
    typedef struct packed {
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cy;
        logic [STEP_X_W-1:0] a;
        logic [STEP_Y_W-1:0] b;
        logic [COLOR_W-1:0]  color;
        logic                done;
    } iter_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int unsigned max_dim);
        logic [31:0] max_v;
        max_v = 32'(max_dim);
        if ({21'b0, v} > max_v)
            return max_v[DIM_W-1:0];
        return v;
    endfunction

endpackage

/* design/mcpg_front.sv */
// Front end: accepts items, holds the circle state and runs the midpoint update.
// Pushes one iteration record per productive item. Uses mcpg_pkg.
module mcpg_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [mcpg_pkg::COORD_W-1:0]  s_center_x,
    input  logic [mcpg_pkg::COORD_W-1:0]  s_center_y,
    input  logic [mcpg_pkg::RADIUS_W-1:0] s_radius,
    input  logic [mcpg_pkg::COLOR_W-1:0]  s_draw_color,
    input  logic                          q_full,
    output logic                          q_push,
    output mcpg_pkg::iter_t               q_data
);

    logic [mcpg_pkg::COORD_W-1:0]    cx_reg, cy_reg;
    logic [mcpg_pkg::STEP_X_W-1:0]   step_x_reg, step_x_next;
    logic [mcpg_pkg::STEP_Y_W-1:0]   step_y_reg, step_y_next;
    logic [mcpg_pkg::DECISION_W-1:0] decision_reg, decision_next;
    logic [mcpg_pkg::COLOR_W-1:0]    color_reg;
    logic                            active_reg;

    logic                            is_start;
    logic [mcpg_pkg::STEP_X_W-1:0]   a;
    logic [mcpg_pkg::STEP_Y_W-1:0]   b;
    logic [mcpg_pkg::DECISION_W-1:0] d;
    logic [mcpg_pkg::DECISION_W-1:0] diff;
    logic signed [mcpg_pkg::STEP_Y_W:0] ny;
    logic [mcpg_pkg::STEP_X_W:0]     nx;
    logic                            done;

    assign s_ready  = !q_full;
    assign is_start = (s_operation == mcpg_pkg::OP_START);

    always_comb begin
        a    = is_start ? '0 : step_x_reg;
        b    = is_start ? {2'b0, s_radius} : step_y_reg;
        d    = is_start ? (16'd3 - {7'b0, s_radius, 1'b0}) : decision_reg;
        diff = {7'b0, a} - {6'b0, b};
        // d is two's complement; the sign bit picks the branch
        if (d[mcpg_pkg::DECISION_W-1]) begin
            decision_next = d + {5'b0, a, 2'b0} + 16'd6;
            ny            = $signed({1'b0, b});
        end else begin
            decision_next = d + {diff[13:0], 2'b0} + 16'd10;
            ny            = $signed({1'b0, b}) - 11'sd1;
        end
        nx          = {1'b0, a} + 10'd1;
        done        = $signed({1'b0, nx}) > ny;
        step_x_next = nx[mcpg_pkg::STEP_X_W-1:0];
        step_y_next = ny[mcpg_pkg::STEP_Y_W] ? '0 : ny[mcpg_pkg::STEP_Y_W-1:0];
    end

    // an advance with no circle in progress is taken and dropped
    assign q_push = s_valid && s_ready && (is_start || active_reg);

    always_comb begin
        q_data.cx    = is_start ? s_center_x : cx_reg;
        q_data.cy    = is_start ? s_center_y : cy_reg;
        q_data.a     = a;
        q_data.b     = b;
        q_data.color = is_start ? s_draw_color : color_reg;
        q_data.done  = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            cx_reg       <= '0;
            cy_reg       <= '0;
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            decision_reg <= '0;
            color_reg    <= '0;
        end else if (q_push) begin
            active_reg   <= !done;
            cx_reg       <= q_data.cx;
            cy_reg       <= q_data.cy;
            color_reg    <= q_data.color;
            step_x_reg   <= step_x_next;
            step_y_reg   <= step_y_next;
            decision_reg <= decision_next;
        end
    end

endmodule

/* design/mcpg_queue.sv */
// Short FIFO of iteration records between front and back.
// Uses mcpg_pkg for the record type and depth.
module mcpg_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mcpg_pkg::iter_t push_data,
    input  logic            pop,
    output logic            head_valid,
    output logic            full,
    output mcpg_pkg::iter_t head
);

    mcpg_pkg::iter_t                mem_reg [mcpg_pkg::QUEUE_DEPTH];
    logic [mcpg_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [mcpg_pkg::QCNT_W-1:0]    count_reg;
    logic                           do_pop;

    localparam logic [mcpg_pkg::QPTR_W-1:0] PTR_LAST = mcpg_pkg::QPTR_W'(mcpg_pkg::QUEUE_DEPTH - 1);
    localparam logic [mcpg_pkg::QCNT_W-1:0] CNT_FULL = mcpg_pkg::QCNT_W'(mcpg_pkg::QUEUE_DEPTH);

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_FULL);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* design/mcpg_back.sv */
// Back end: walks the eight symmetric points of the queue head, one per cycle while the
// output is not stalled, clips each and forms its byte address into the output register. Uses mcpg_pkg.
module mcpg_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  mcpg_pkg::iter_t                     q_head,
    output logic                                q_pop,
    input  logic [mcpg_pkg::DIM_W-1:0]          screen_w,
    input  logic [mcpg_pkg::DIM_W-1:0]          screen_h,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mcpg_pkg::POINT_W-1:0] m_point_x,
    output logic signed [mcpg_pkg::POINT_W-1:0] m_point_y,
    output logic                                m_in_range,
    output logic [mcpg_pkg::ADDR_W-1:0]         m_byte_address,
    output logic [mcpg_pkg::COLOR_W-1:0]        m_pixel_color,
    output logic                                m_last_of_step,
    output logic                                m_circle_done
);

    logic [2:0]                         idx_reg;
    logic                               valid_reg;
    logic [mcpg_pkg::POINT_W-1:0]       px_reg, py_reg;
    logic                               in_range_reg;
    logic [mcpg_pkg::ADDR_W-1:0]        addr_reg;
    logic [mcpg_pkg::COLOR_W-1:0]       color_reg;
    logic                               last_reg, done_reg;

    logic                               adv;
    logic [mcpg_pkg::STEP_Y_W-1:0]      u, v;
    logic signed [11:0]                 px, py;
    logic                               ok;
    logic [21:0]                        lin;
    logic [mcpg_pkg::ADDR_W-1:0]        addr;

    assign adv   = q_valid && (!valid_reg || m_ready);
    assign q_pop = adv && (idx_reg == 3'd7);

    // idx[2] swaps the octant pair, idx[1] negates x offset, idx[0] negates y offset
    always_comb begin
        u   = idx_reg[2] ? q_head.b : {1'b0, q_head.a};
        v   = idx_reg[2] ? {1'b0, q_head.a} : q_head.b;
        px  = idx_reg[1] ? $signed({4'b0, q_head.cx}) - $signed({2'b0, u})
                         : $signed({4'b0, q_head.cx}) + $signed({2'b0, u});
        py  = idx_reg[0] ? $signed({4'b0, q_head.cy}) - $signed({2'b0, v})
                         : $signed({4'b0, q_head.cy}) + $signed({2'b0, v});
        ok  = !px[11] && !py[11]
              && (px[10:0] < screen_w) && (py[10:0] < screen_h);
        lin = 22'(py[9:0] * screen_w) + {12'b0, px[9:0]};
        addr = ok ? {lin[19:0], 1'b0} : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                idx_reg   <= idx_reg + 1'b1;
                valid_reg <= 1'b1;
            end else if (m_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg       <= px[mcpg_pkg::POINT_W-1:0];
            py_reg       <= py[mcpg_pkg::POINT_W-1:0];
            in_range_reg <= ok;
            addr_reg     <= addr;
            color_reg    <= q_head.color;
            last_reg     <= (idx_reg == 3'd7);
            done_reg     <= q_head.done;
        end
    end

    assign m_valid        = valid_reg;
    assign m_point_x      = $signed(px_reg);
    assign m_point_y      = $signed(py_reg);
    assign m_in_range     = in_range_reg;
    assign m_byte_address = addr_reg;
    assign m_pixel_color  = color_reg;
    assign m_last_of_step = last_reg;
    assign m_circle_done  = done_reg;

endmodule

/* design/midpoint_circle_point_generator_core.sv */
// Top level of the midpoint circle point generator: config registers, front, queue, back.
// Depends on mcpg_pkg, mcpg_front, mcpg_queue and mcpg_back.
//
// Each start item (and each advance while a circle is in progress) yields eight
// points, one per clock while m_ready does not stall the output; the back
// end's single point datapath (clip compares and the row*width address multiply)
// sets that rate. A two-entry queue lets the front take the next item while the
// back is still emitting, and the output register lets the next point form in the
// same cycle the previous one is taken. The first point passes through the queue and
// then the output register. Advances with no circle in progress are taken and give nothing.
// Screen sizes above MAX_DIM are clamped when written; a size of zero puts every
// point out of range.
module midpoint_circle_point_generator_core #(
    parameter int unsigned MAX_DIM = mcpg_pkg::MAX_DIM_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [mcpg_pkg::DIM_W-1:0]          cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [mcpg_pkg::COORD_W-1:0]        s_center_x,
    input  logic [mcpg_pkg::COORD_W-1:0]        s_center_y,
    input  logic [mcpg_pkg::RADIUS_W-1:0]       s_radius,
    input  logic [mcpg_pkg::COLOR_W-1:0]        s_draw_color,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mcpg_pkg::POINT_W-1:0] m_point_x,
    output logic signed [mcpg_pkg::POINT_W-1:0] m_point_y,
    output logic                                m_in_range,
    output logic [mcpg_pkg::ADDR_W-1:0]         m_byte_address,
    output logic [mcpg_pkg::COLOR_W-1:0]        m_pixel_color,
    output logic                                m_last_of_step,
    output logic                                m_circle_done
);

    logic [mcpg_pkg::DIM_W-1:0] width_reg, height_reg;
    logic                       q_full, q_push, q_pop, q_valid;
    mcpg_pkg::iter_t            q_in, q_head;

    // sizes are stored already clamped to MAX_DIM
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= mcpg_pkg::clamp_dim(mcpg_pkg::DIM_RESET, MAX_DIM);
            height_reg <= mcpg_pkg::clamp_dim(mcpg_pkg::DIM_RESET, MAX_DIM);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mcpg_pkg::REG_SCREEN_WIDTH:
                    width_reg <= mcpg_pkg::clamp_dim(cfg_wr_data, MAX_DIM);
                mcpg_pkg::REG_SCREEN_HEIGHT:
                    height_reg <= mcpg_pkg::clamp_dim(cfg_wr_data, MAX_DIM);
                default: ;
            endcase
        end
    end

    mcpg_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_center_x   (s_center_x),
        .s_center_y   (s_center_y),
        .s_radius     (s_radius),
        .s_draw_color (s_draw_color),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    mcpg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .pop        (q_pop),
        .head_valid (q_valid),
        .full       (q_full),
        .head       (q_head)
    );

    mcpg_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .screen_w       (width_reg),
        .screen_h       (height_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_point_x      (m_point_x),
        .m_point_y      (m_point_y),
        .m_in_range     (m_in_range),
        .m_byte_address (m_byte_address),
        .m_pixel_color  (m_pixel_color),
        .m_last_of_step (m_last_of_step),
        .m_circle_done  (m_circle_done)
    );

endmodule

/* tb/sv/midpoint_circle_point_generator_core_tb.sv */
// Self-checking testbench for midpoint_circle_point_generator_core: directed and random
// circles over several screen sizes, every point checked against an in-bench circle tracer.
// Depends on mcpg_pkg and the core RTL only.
module midpoint_circle_point_generator_core_tb;
    import mcpg_pkg::*;

    typedef struct {
        op_t                 op;
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cy;
        logic [RADIUS_W-1:0] r;
        logic [COLOR_W-1:0]  color;
    } circle_cmd_t;

    typedef struct {
        logic signed [POINT_W-1:0] px;
        logic signed [POINT_W-1:0] py;
        logic                      ok;
        logic [ADDR_W-1:0]         addr;
        logic [COLOR_W-1:0]        color;
        logic                      last;
        logic                      done;
    } plot_word_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic                         cfg_index;
    logic [DIM_W-1:0]             cfg_wr_data;
    logic                         s_valid;
    logic                         s_ready;
    logic                         s_operation;
    logic [COORD_W-1:0]           s_center_x;
    logic [COORD_W-1:0]           s_center_y;
    logic [RADIUS_W-1:0]          s_radius;
    logic [COLOR_W-1:0]           s_draw_color;
    logic                         m_valid;
    logic                         m_ready;
    logic signed [POINT_W-1:0]    m_point_x;
    logic signed [POINT_W-1:0]    m_point_y;
    logic                         m_in_range;
    logic [ADDR_W-1:0]            m_byte_address;
    logic [COLOR_W-1:0]           m_pixel_color;
    logic                         m_last_of_step;
    logic                         m_circle_done;

    // tracer state
    logic [DIM_W-1:0]             scr_w;
    logic [DIM_W-1:0]             scr_h;
    logic [COORD_W-1:0]           ctr_x;
    logic [COORD_W-1:0]           ctr_y;
    logic [STEP_X_W-1:0]          arc_x;
    logic [STEP_Y_W-1:0]          arc_y;
    logic signed [DECISION_W-1:0] mid_err;
    logic [COLOR_W-1:0]           pen_color;
    bit                           tracing;

    circle_cmd_t                  cmd_q[$];
    plot_word_t                   point_q[$];
    int                           cmds_queued;
    int                           cmds_taken;
    int                           plotting_cmds;
    int                           word_cnt;
    int                           err_cnt;
    int                           gap_left;
    int                           stall_left;
    bit                           idle_on;
    bit                           stall_on;
    bit                           s_taken;
    int unsigned                  phase_w[7];
    int unsigned                  phase_h[7];

    midpoint_circle_point_generator_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_center_x     (s_center_x),
        .s_center_y     (s_center_y),
        .s_radius       (s_radius),
        .s_draw_color   (s_draw_color),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_point_x      (m_point_x),
        .m_point_y      (m_point_y),
        .m_in_range     (m_in_range),
        .m_byte_address (m_byte_address),
        .m_pixel_color  (m_pixel_color),
        .m_last_of_step (m_last_of_step),
        .m_circle_done  (m_circle_done)
    );

    always #1 aclk = ~aclk;

    function automatic plot_word_t plot_point(int px, int py, bit last, bit done);
        plot_word_t w;
        int         wd;
        int         ht;
        wd = (scr_w > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : int'(scr_w);
        ht = (scr_h > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : int'(scr_h);
        w.px    = px[POINT_W-1:0];
        w.py    = py[POINT_W-1:0];
        // negative coordinates clip like an unsigned wrap would
        w.ok    = px >= 0 && py >= 0 && px < wd && py < ht;
        w.addr  = w.ok ? ADDR_W'((py * wd + px) * 2) : '0;
        w.color = pen_color;
        w.last  = last;
        w.done  = done;
        return w;
    endfunction

    // one midpoint iteration: eight octant points, then the decision update
    task automatic trace_iteration();
        int cx;
        int cy;
        int a;
        int b;
        int nx;
        int ny;
        int nd;
        bit done;
        cx = ctr_x;
        cy = ctr_y;
        a  = arc_x;
        b  = arc_y;
        if (mid_err < 0) begin
            nd = mid_err + 4 * a + 6;
            ny = b;
        end else begin
            nd = mid_err + 4 * (a - b) + 10;
            ny = b - 1;
        end
        nx   = a + 1;
        done = nx > ny;
        point_q.push_back(plot_point(cx + a, cy + b, 1'b0, done));
        point_q.push_back(plot_point(cx + a, cy - b, 1'b0, done));
        point_q.push_back(plot_point(cx - a, cy + b, 1'b0, done));
        point_q.push_back(plot_point(cx - a, cy - b, 1'b0, done));
        point_q.push_back(plot_point(cx + b, cy + a, 1'b0, done));
        point_q.push_back(plot_point(cx + b, cy - a, 1'b0, done));
        point_q.push_back(plot_point(cx - b, cy + a, 1'b0, done));
        point_q.push_back(plot_point(cx - b, cy - a, 1'b1, done));
        mid_err = nd[DECISION_W-1:0];
        arc_x   = nx[STEP_X_W-1:0];
        arc_y   = (ny < 0) ? '0 : ny[STEP_Y_W-1:0];
        tracing = !done;
    endtask

    task automatic trace_command(circle_cmd_t c);
        if (c.op == OP_START) begin
            ctr_x     = c.cx;
            ctr_y     = c.cy;
            pen_color = c.color;
            arc_x     = '0;
            arc_y     = STEP_Y_W'(c.r);
            mid_err   = DECISION_W'(3 - 2 * int'(c.r));
            tracing   = 1'b1;
        end
        if (c.op == OP_START || tracing) begin
            trace_iteration();
            plotting_cmds++;
        end
    endtask

    task automatic flag_error(string msg);
        $display("[%0t] ERROR word %0d: %s", $time, word_cnt, msg);
        err_cnt++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task automatic queue_cmd(op_t op, int cx, int cy, int r, int color);
        circle_cmd_t c;
        c.op    = op;
        c.cx    = cx[COORD_W-1:0];
        c.cy    = cy[COORD_W-1:0];
        c.r     = r[RADIUS_W-1:0];
        c.color = color[COLOR_W-1:0];
        cmd_q.push_back(c);
        cmds_queued++;
    endtask

    task automatic queue_advances(int n);
        repeat (n)
            queue_cmd(OP_ADVANCE, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 65535));
    endtask

    // a lone advance now and then; else a start with random content, then a full, cut-short or partial trace of it
    task automatic queue_random_circle();
        int r;
        int n;
        int pick;
        if ($urandom_range(0, 99) < 8) begin
            queue_advances(1);
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 65)
            r = $urandom_range(0, 12);
        else if (pick < 92)
            r = $urandom_range(13, 48);
        else
            r = $urandom_range(49, 255);
        queue_cmd(OP_START, $urandom_range(0, 255), $urandom_range(0, 255), r,
                  $urandom_range(0, 65535));
        if (r > 48)
            n = $urandom_range(0, 6);
        else if ($urandom_range(0, 4) == 0)
            n = $urandom_range(0, r / 2);
        else
            n = (r * 3) / 4 + $urandom_range(0, 2);
        queue_advances(n);
    endtask

    task automatic wait_idle(int settle);
        while (cmds_taken != cmds_queued || point_q.size() != 0)
            @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_screen(reg_index_t idx, int unsigned val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val[DIM_W-1:0];
        if (idx == REG_SCREEN_WIDTH)
            scr_w = val[DIM_W-1:0];
        else
            scr_h = val[DIM_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // sender: pops the next word, or idles for a random gap, unless one is still waiting for ready
    always @(negedge aclk) begin
        circle_cmd_t c;
        if (aresetn && (!s_valid || s_taken)) begin
            s_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (idle_on && cmd_q.size() > 0 && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 11);
                s_valid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                c = cmd_q.pop_front();
                s_operation  <= c.op;
                s_center_x   <= c.cx;
                s_center_y   <= c.cy;
                s_radius     <= c.r;
                s_draw_color <= c.color;
                s_valid      <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        circle_cmd_t c;
        if (aresetn && s_valid && s_ready) begin
            c.op    = op_t'(s_operation);
            c.cx    = s_center_x;
            c.cy    = s_center_y;
            c.r     = s_radius;
            c.color = s_draw_color;
            trace_command(c);
            s_taken = 1'b1;
            cmds_taken++;
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        plot_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (point_q.size() == 0) begin
                flag_error("point word with nothing expected");
            end else begin
                e = point_q.pop_front();
                check_field("point_x", m_point_x, e.px);
                check_field("point_y", m_point_y, e.py);
                check_field("in_range", m_in_range, e.ok);
                check_field("byte_address", m_byte_address, e.addr);
                check_field("pixel_color", m_pixel_color, e.color);
                check_field("last_of_step", m_last_of_step, e.last);
                check_field("circle_done", m_circle_done, e.done);
            end
            word_cnt++;
        end
    end

    initial begin
        int target;
        aclk          = 1'b0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_operation   = 1'b0;
        s_center_x    = '0;
        s_center_y    = '0;
        s_radius      = '0;
        s_draw_color  = '0;
        m_ready       = 1'b0;
        scr_w         = DIM_RESET;
        scr_h         = DIM_RESET;
        ctr_x         = '0;
        ctr_y         = '0;
        arc_x         = '0;
        arc_y         = '0;
        mid_err       = '0;
        pen_color     = '0;
        tracing       = 1'b0;
        cmds_queued   = 0;
        cmds_taken    = 0;
        plotting_cmds = 0;
        word_cnt      = 0;
        err_cnt       = 0;
        gap_left      = 0;
        stall_left    = 0;
        s_taken       = 1'b0;
        idle_on       = 1'b1;
        stall_on      = 1'b1;
        phase_w       = '{1024, 0, 700, 1, 2047, 300, 0};
        phase_h       = '{1024, 700, 0, 1, 2047, 1023, 0};
        phase_w[6]    = $urandom_range(1, 1024);
        phase_h[6]    = $urandom_range(1, 1024);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed pass at the reset screen size
        queue_cmd(OP_ADVANCE, 0, 0, 0, 0);              // nothing in progress yet
        queue_cmd(OP_START, 0, 0, 0, 16'h0000);         // zero radius: single step
        queue_cmd(OP_ADVANCE, 255, 255, 255, 16'hFFFF); // after done: ignored
        queue_cmd(OP_START, 255, 255, 255, 16'hFFFF);   // reaches x,y = 510
        queue_advances(2);
        queue_cmd(OP_START, 0, 0, 255, 16'h8001);       // negative coordinates
        queue_advances(1);
        queue_cmd(OP_START, 127, 127, 1, 16'h1234);     // right at the screen edge
        queue_advances(1);
        queue_cmd(OP_START, 64, 64, 5, 16'hA5A5);
        queue_advances(2);
        queue_cmd(OP_START, 10, 200, 3, 16'h5A5A);      // drops the circle in progress
        queue_advances(2);
        queue_cmd(OP_START, 128, 0, 2, 16'h00FF);
        queue_advances(2);
        wait_idle(8);

        for (int p = 0; p < 7; p++) begin
            write_screen(REG_SCREEN_WIDTH, phase_w[p]);
            write_screen(REG_SCREEN_HEIGHT, phase_h[p]);
            if (p == 6) begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end
            target = plotting_cmds + 35;
            while (plotting_cmds + (cmds_queued - cmds_taken) < target) begin
                queue_random_circle();
                while (cmds_queued - cmds_taken > 8)
                    @(negedge aclk);
            end
            wait_idle(8);
        end

        repeat (12) @(negedge aclk);
        if (err_cnt == 0 && point_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* midpoint_circle_point_generator_core.f */
design/mcpg_pkg.sv
design/mcpg_front.sv
design/mcpg_queue.sv
design/mcpg_back.sv
design/midpoint_circle_point_generator_core.sv
tb/sv/midpoint_circle_point_generator_core_tb.sv
